[rtl/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

   // Stream fill counter, saturating.
   localparam int unsigned FILL_WIDTH = 6;
   localparam logic [FILL_WIDTH-1:0] FILL_MAX = 6'd63;

   // Half-window register.
   localparam int unsigned CSR_WIDTH = 4;
   localparam logic [CSR_WIDTH-1:0] HALF_RESET = 4'd1;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_READ      = 5'b00010,
      ST_LAST_ACC  = 5'b00100,
      ST_DIV_START = 5'b01000,
      ST_DIVIDE    = 5'b10000
   } state_type;

endpackage

[rtl/cma_divider.sv]
// ----------------------------------------------------------------------------
// cma_divider
// Serial signed divider: one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module cma_divider #(
   parameter int DVD_WIDTH = 22,
   parameter int DVS_WIDTH = 6,
   parameter int QUO_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DVD_WIDTH-1:0] dividend,
   input  logic        [DVS_WIDTH-1:0] divisor,
   output logic                        done,
   output logic signed [QUO_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = (DVD_WIDTH > 1) ? $clog2(DVD_WIDTH) : 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DVS_WIDTH-1:0] rem_ff, rem_in;
   logic [DVS_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DVD_WIDTH-1:0] quo_ff, quo_in;
   logic                 neg_ff, neg_in;

   logic [DVS_WIDTH:0]   trial;
   logic                 fits;
   logic [DVS_WIDTH:0]   diff;
   logic [DVD_WIDTH-1:0] quo_signed;

   // restoring step
   assign trial = {rem_ff, quo_ff[DVD_WIDTH-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_WIDTH'(DVD_WIDTH - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[DVD_WIDTH-1];
         quo_in  = dividend[DVD_WIDTH-1] ? DVD_WIDTH'(-dividend) : DVD_WIDTH'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_WIDTH-1:0] : trial[DVS_WIDTH-1:0];
         quo_in = {quo_ff[DVD_WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign quo_signed = neg_ff ? (~quo_ff + DVD_WIDTH'(1)) : quo_ff;
   assign quotient   = quo_signed[QUO_WIDTH-1:0];
   assign done       = done_ff;

endmodule

[rtl/centered_moving_average.sv]
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered moving average over a stream of signed fixed-point samples, with
// the window cut short at both ends of the stream.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   req     | in        | req_valid/req_stall | req_sample, req_last
//   rsp     | out       | rsp_valid/rsp_stall | rsp_average, rsp_last_out
//   csr     | in        | csr_wr_en           | csr_wr_data (half window)
//
// A word that produces no result is done in its accept cycle. A word with
// results takes its accept cycle, then per result (hi + 1) history reads,
// one last accumulate, one divider start and a serial divide, where hi + 1
// is the window size.
// A flush word produces up to h+1 results back to back through the same path.
// Reset is synchronous; no clearing pass, the history memory is never read
// beyond what the current stream has written.
// req_stall is high whenever a word is in work; a stalled result sits in the
// output register while the next request word is already taken.
// ----------------------------------------------------------------------------
module centered_moving_average #(
   parameter int MAX_HALF     = 15,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_average,
   output logic                           rsp_last_out,
   // config
   input  logic                           csr_wr_en,
   input  logic [cma_pkg::CSR_WIDTH-1:0]  csr_wr_data
);

   localparam int FW         = cma_pkg::FILL_WIDTH;
   localparam int HIST_DEPTH = 2 * MAX_HALF + 2;
   localparam int AW         = $clog2(HIST_DEPTH);
   localparam int MEM_DEPTH  = 1 << AW;
   localparam int HW         = $clog2(MAX_HALF + 1);
   localparam int SUM_WIDTH  = SAMPLE_WIDTH + FW;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   cma_pkg::state_type state_ff, state_in;

   logic [cma_pkg::CSR_WIDTH-1:0] half_ff, half_in;   // csr
   logic [FW-1:0]  fill_ff, fill_in;                  // samples in stream
   logic [AW-1:0]  wp_ff, wp_in;                      // next write address
   logic [FW-1:0]  n_ff, n_in;                        // fill seen by this word
   logic [HW-1:0]  h_ff, h_in;                        // half width for this word
   logic           last_ff, last_in;                  // word is a flush
   logic [FW-1:0]  age_ff, age_in;                    // center age of result
   logic [FW-1:0]  rd_cnt_ff, rd_cnt_in;              // age being read
   logic           acc_vld_ff;                        // rd_data_ff is live
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_average_ff, rsp_average_in;
   logic                           rsp_last_out_ff, rsp_last_out_in;

   // history memory, circular; newest sample sits at wp_ff - 1
   logic [SAMPLE_WIDTH-1:0] hist_mem [MEM_DEPTH];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]           rd_addr;

   // ------------------------------------------------------------------
   // combinational helpers
   // ------------------------------------------------------------------
   logic            accept;
   logic            slot_free;
   logic            out_load;
   logic            out_last;
   logic [HW-1:0]   h_clamp;
   logic [FW-1:0]   fill_next;
   logic [FW-1:0]   fill_next_m1;
   logic [FW-1:0]   first_age;
   logic [FW:0]     age_plus_h;
   logic [FW-1:0]   n_m1;
   logic [FW-1:0]   hi_w;            // oldest age in the window
   logic            div_start;
   logic            div_done;
   logic signed [SAMPLE_WIDTH-1:0] div_quo;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign h_clamp = (32'(half_ff) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_ff);

   assign fill_next    = (fill_ff == cma_pkg::FILL_MAX) ? fill_ff : fill_ff + FW'(1);
   assign fill_next_m1 = fill_next - FW'(1);
   assign first_age    = (FW'(h_clamp) < fill_next_m1) ? FW'(h_clamp) : fill_next_m1;

   // every window starts at the newest sample (age 0); it reaches back to
   // age + h, or to the oldest sample of the stream when that is nearer
   assign age_plus_h = (FW + 1)'(age_ff) + (FW + 1)'(h_ff);
   assign n_m1       = n_ff - FW'(1);
   assign hi_w       = (age_plus_h < (FW + 1)'(n_m1)) ? age_plus_h[FW-1:0] : n_m1;

   assign rd_addr   = wp_ff - AW'(1) - rd_cnt_ff[AW-1:0];
   assign div_start = (state_ff == cma_pkg::ST_DIV_START);
   assign out_load  = (state_ff == cma_pkg::ST_DIVIDE) && div_done && slot_free;
   assign out_last  = last_ff && (age_ff == '0);

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      half_in         = csr_wr_en ? csr_wr_data : half_ff;
      fill_in         = fill_ff;
      wp_in           = wp_ff;
      n_in            = n_ff;
      h_in            = h_ff;
      last_in         = last_ff;
      age_in          = age_ff;
      rd_cnt_in       = '0;
      sum_in          = sum_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_average_in  = rsp_average_ff;
      rsp_last_out_in = rsp_last_out_ff;

      unique case (state_ff)
         cma_pkg::ST_IDLE: begin
            sum_in = '0;
            if (accept) begin
               wp_in   = wp_ff + AW'(1);
               n_in    = fill_next;
               h_in    = h_clamp;
               last_in = req_last;
               fill_in = req_last ? '0 : fill_next;
               age_in  = req_last ? first_age : FW'(h_clamp);
               // plain word: a result only once h+1 samples are in
               if (req_last || (fill_next > FW'(h_clamp))) begin
                  state_in = cma_pkg::ST_READ;
               end
            end
         end
         cma_pkg::ST_READ: begin
            rd_cnt_in = rd_cnt_ff + FW'(1);
            if (acc_vld_ff) begin
               sum_in = sum_ff + SUM_WIDTH'(signed'(rd_data_ff));
            end
            if (rd_cnt_ff == hi_w) begin
               state_in = cma_pkg::ST_LAST_ACC;
            end
         end
         cma_pkg::ST_LAST_ACC: begin
            sum_in   = sum_ff + SUM_WIDTH'(signed'(rd_data_ff));
            state_in = cma_pkg::ST_DIV_START;
         end
         cma_pkg::ST_DIV_START: begin
            state_in = cma_pkg::ST_DIVIDE;
         end
         cma_pkg::ST_DIVIDE: begin
            sum_in = '0;
            if (out_load) begin
               rsp_valid_in    = 1'b1;
               rsp_average_in  = div_quo;
               rsp_last_out_in = out_last;
               // flush walks toward the newest sample
               if (last_ff && (age_ff != '0)) begin
                  age_in   = age_ff - FW'(1);
                  state_in = cma_pkg::ST_READ;
               end else begin
                  state_in = cma_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cma_pkg::ST_IDLE;
         half_ff      <= cma_pkg::HALF_RESET;
         fill_ff      <= '0;
         wp_ff        <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         acc_vld_ff   <= (state_ff == cma_pkg::ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      h_ff            <= h_in;
      last_ff         <= last_in;
      age_ff          <= age_in;
      rd_cnt_ff       <= rd_cnt_in;
      sum_ff          <= sum_in;
      rsp_average_ff  <= rsp_average_in;
      rsp_last_out_ff <= rsp_last_out_in;
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wp_ff] <= req_sample;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // divider
   // ------------------------------------------------------------------
   cma_divider #(
      .DVD_WIDTH (SUM_WIDTH),
      .DVS_WIDTH (FW),
      .QUO_WIDTH (SAMPLE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (hi_w + FW'(1)),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   assign req_stall    = (state_ff != cma_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_average  = rsp_average_ff;
   assign rsp_last_out = rsp_last_out_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // reads stay inside what the current stream has written
   a_read_in_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cma_pkg::ST_READ) |-> (hi_w < n_ff) && (rd_cnt_ff <= hi_w))
      else $error("history read beyond stream fill");

   // a fresh divide must not see a stale done
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cma_pkg::ST_DIVIDE) && $past(state_ff == cma_pkg::ST_DIV_START)
      |-> !div_done)
      else $error("divider done not cleared by start");

   // final result of a flush leaves the block idle with an empty stream
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      out_load && out_last |=> (state_ff == cma_pkg::ST_IDLE) && (fill_ff == '0))
      else $error("flush did not restart the stream");

   // a result is loaded only into a free output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("pending result overwritten");

endmodule

[tb/centered_moving_average_tb.sv]
// ----------------------------------------------------------------------------
// centered_moving_average_tb
// Self-checking bench for the centered moving average. Words go in through a
// burst-mode sender. Each accepted word is run through a local smoothing
// model that queues the expected means. A checker on the result channel
// compares every result word with the oldest queued mean. The receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module centered_moving_average_tb;

   localparam int MAX_HALF     = 15;
   localparam int SAMPLE_WIDTH = 16;
   localparam int HIST_DEPTH   = 2 * MAX_HALF + 2;
   localparam int RANDOM_WORDS = 150;
   // Settle time after the last expected mean. A word without a result
   // is done in the cycle it is taken, so a short pause is enough.
   localparam int SETTLE_CYCLES = 12;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] average;
      logic                           last_out;
   } smoothed_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   sample_type                    req_sample;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_stall;
   sample_type                    rsp_average;
   logic                          rsp_last_out;
   logic                          csr_wr_en;
   logic [cma_pkg::CSR_WIDTH-1:0] csr_wr_data;

   // Local copy of the block's state, used to predict the means.
   sample_type                    window_hist [HIST_DEPTH];
   int unsigned                   stream_fill;
   logic [cma_pkg::CSR_WIDTH-1:0] half_setting;
   smoothed_type                  pending_means [$];

   int                      failures;
   // Sender burst control.
   int                      burst_left;
   bit                      sender_eager;
   // Receiver control: the tests post a hold request, the receiver counts it.
   int                      hold_req;
   int                      hold_left;
   int unsigned             stall_phase;

   centered_moving_average #(
      .MAX_HALF     (MAX_HALF),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_average  (rsp_average),
      .rsp_last_out (rsp_last_out),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Smoothing model
   // -------------------------------------------------------------------------

   // Mean over ages lo..hi, truncated toward zero.
   function automatic sample_type window_mean(input int unsigned lo, input int unsigned hi);
      longint sum;
      sum = 0;
      for (int unsigned k = lo; k <= hi; k++) begin
         sum += window_hist[k];
      end
      return sample_type'(sum / longint'(hi - lo + 1));
   endfunction

   // Shift one accepted word in and queue the means it releases.
   function automatic void predict_smoothing(input sample_type sample, input logic last);
      int unsigned  h;
      int unsigned  n;
      int unsigned  lo;
      int unsigned  hi;
      int           age;
      smoothed_type mean_word;
      h = (half_setting > MAX_HALF) ? MAX_HALF : half_setting;
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         window_hist[k] = window_hist[k-1];
      end
      window_hist[0] = sample;
      if (stream_fill < cma_pkg::FILL_MAX) begin
         stream_fill++;
      end
      n = stream_fill;
      if (!last) begin
         // Mean for the sample h words back, once it has its right side.
         if (n > h) begin
            hi = (2 * h < n - 1) ? 2 * h : n - 1;
            mean_word.average  = window_mean(0, hi);
            mean_word.last_out = 1'b0;
            pending_means.push_back(mean_word);
         end
         return;
      end
      // Last word: flush every pending sample, oldest first, windows cut
      // short on the newest side.
      for (age = int'((h < n - 1) ? h : n - 1); age >= 0; age--) begin
         lo = (age > h) ? age - h : 0;
         hi = (age + h < n - 1) ? age + h : n - 1;
         mean_word.average  = window_mean(lo, hi);
         mean_word.last_out = (age == 0);
         pending_means.push_back(mean_word);
      end
      stream_fill = 0;
   endfunction

   // -------------------------------------------------------------------------
   // Result checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      smoothed_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected result word: average %0d last_out %0b",
                     $time, rsp_average, rsp_last_out);
            failures++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_average !== want.average) begin
               $display("%0t: average mismatch: expected %0d, actual %0d",
                        $time, want.average, rsp_average);
               failures++;
            end
            if (rsp_last_out !== want.last_out) begin
               $display("%0t: last_out mismatch: expected %0b, actual %0b",
                        $time, want.last_out, rsp_last_out);
               failures++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall pattern cycles through four moods, one of them stall-free.
   // A posted hold overrides it for a stretch.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      stall_phase++;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case ((stall_phase / 64) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_phase % 3 != 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Offer one word and hold it until taken. Gaps are inserted between
   // bursts unless the sender is running eager.
   task automatic send_word(input sample_type sample, input logic last);
      int gap;
      if (!sender_eager && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      req_last   <= last;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      predict_smoothing(sample, last);
   endtask

   // Drop valid and wait until every queued mean has come out.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_means.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only done with the block idle.
   task automatic write_half(input int unsigned h);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h[cma_pkg::CSR_WIDTH-1:0];
      @(posedge clock);
      half_setting = h[cma_pkg::CSR_WIDTH-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return sample_type'(16'h8000);
         1: return sample_type'(16'h7fff);
         2: return sample_type'(int'($urandom_range(0, 8)) - 4);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Mostly narrow windows, now and then a wide one.
   function automatic int unsigned pick_half();
      case ($urandom_range(0, 9)) inside
         [0:5]:   return $urandom_range(0, 3);
         [6:8]:   return $urandom_range(4, 9);
         default: return $urandom_range(10, 15);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset half width of one: single-word stream, saturated sums of both
   // signs, and a negative mean that must truncate toward zero.
   task automatic test_reset_window();
      send_word(16'sd5, 1'b1);
      repeat (2) send_word(16'sh7fff, 1'b0);
      send_word(16'sh7fff, 1'b1);
      repeat (2) send_word(-16'sd32768, 1'b0);
      send_word(-16'sd32768, 1'b1);
      send_word(-16'sd7, 1'b0);
      send_word(16'sd2, 1'b0);
      send_word(16'sd0, 1'b0);
      send_word(16'sd1, 1'b1);
   endtask

   // Half width zero (mean is the word itself) and fifteen (flush of a
   // stream shorter than the window).
   task automatic test_window_extremes();
      write_half(0);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd100, 1'b0);
      send_word(-16'sd32768, 1'b1);
      write_half(15);
      send_word(16'sh7fff, 1'b0);
      send_word(-16'sd3, 1'b0);
      send_word(16'sd11, 1'b0);
      send_word(-16'sd32768, 1'b1);
   endtask

   // Half width changed between two words of one stream.
   task automatic test_midstream_change();
      write_half(2);
      send_word(16'sd40, 1'b0);
      send_word(-16'sd9, 1'b0);
      send_word(16'sd1000, 1'b0);
      send_word(16'sd3, 1'b0);
      write_half(5);
      send_word(-16'sd250, 1'b0);
      send_word(16'sd77, 1'b0);
      send_word(16'sd12, 1'b1);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // back to back, so the block backs up and stalls its input.
   task automatic test_output_backpressure();
      write_half(3);
      sender_eager = 1'b1;
      hold_req = 400;
      for (int k = 0; k < 24; k++) begin
         send_word(random_sample(), k == 23);
      end
      sender_eager = 1'b0;
      wait_idle();
   endtask

   // Random streams with random content. The first one runs past the fill
   // counter's saturation point.
   task automatic test_random_streams();
      int sent;
      int len;
      int unsigned h;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 1) == 0) begin
            write_half(pick_half());
         end
         h = half_setting;
         if (sent == 0) begin
            len = 70;
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(30, 70);
         end else begin
            len = $urandom_range(1, 2 * h + 6);
         end
         sender_eager = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            if (k > 0 && k < len - 1 && $urandom_range(0, 39) == 0) begin
               write_half(pick_half());
            end
            send_word(random_sample(), k == len - 1);
         end
         sent += len;
      end
      sender_eager = 1'b0;
      wait_idle();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      req_last     = 1'b0;
      rsp_stall    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      failures     = 0;
      burst_left   = 0;
      sender_eager = 1'b0;
      hold_req     = 0;
      hold_left    = 0;
      stall_phase  = 0;
      stream_fill  = 0;
      half_setting = cma_pkg::HALF_RESET;
      for (int k = 0; k < HIST_DEPTH; k++) begin
         window_hist[k] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_window_extremes();
      test_midstream_change();
      test_output_backpressure();
      test_random_streams();

      wait_idle();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
rtl/cma_pkg.sv
rtl/cma_divider.sv
rtl/centered_moving_average.sv
tb/centered_moving_average_tb.sv
